[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers used by sprite_row_planar_decode
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// same-cycle implication, checked while out of reset
`define ASSERT_IMPLIES(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("assertion failed");

// next-cycle implication, checked while out of reset
`define ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst, cond, expr)
`define ASSERT_NEXT(label, clk, rst, cond, expr)

`endif

`endif

[design/srpd_pkg.sv]
// ----------------------------------------------------------------------------
// srpd_pkg
// types and constants for the planar sprite row decoder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package srpd_pkg;

   localparam int PLANES      = 4;
   localparam int PLANE_W     = 16;
   localparam int PAL_W       = 4;
   localparam int OFFSET_W    = 4;
   localparam int COLOR_W     = 8;
   localparam int REQ_DATA_W  = 64;
   localparam int REQ_USER_W  = 6;
   localparam int RSP_DATA_W  = 16;
   localparam int RSP_USER_W  = 2;

   localparam logic [OFFSET_W-1:0] LAST_OFFSET = 4'hF;

   typedef logic [PLANE_W-1:0] plane_type;

   // one buffered sprite row
   typedef struct packed {
      plane_type [PLANES-1:0] plane;
      logic [PAL_W-1:0]       palette_number;
      logic                   mirror;
      logic                   in_front;
   } row_type;

   // one decoded pixel
   typedef struct packed {
      logic [OFFSET_W-1:0] pixel_offset;
      logic [COLOR_W-1:0]  color_index;
      logic                opaque;
      logic                front_mark;
      logic                last_pixel;
   } pixel_type;

endpackage

[design/srpd_pixel_sel.sv]
// ----------------------------------------------------------------------------
// srpd_pixel_sel
// picks one pixel column out of the four bit planes and forms its result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module srpd_pixel_sel (
   input  srpd_pkg::row_type                     row,
   input  logic [srpd_pkg::OFFSET_W-1:0]         offset,
   output srpd_pkg::pixel_type                   pixel
);
   import srpd_pkg::*;

   logic [OFFSET_W-1:0] bit_sel;
   logic [PLANES-1:0]   value;

   // unflipped rows read from the msb side
   assign bit_sel = row.mirror ? offset : ~offset;

   always_comb begin
      for (int k = 0; k < PLANES; k++) begin
         value[k] = row.plane[k][bit_sel];
      end
   end

   always_comb begin
      pixel.pixel_offset = offset;
      pixel.color_index  = {row.palette_number, value};
      pixel.opaque       = |value;
      pixel.front_mark   = row.in_front & (|value);
      pixel.last_pixel   = (offset == LAST_OFFSET);
   end

endmodule

[design/srpd_out_reg.sv]
// ----------------------------------------------------------------------------
// srpd_out_reg
// result register between the pixel select and the result channel
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module srpd_out_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  srpd_pkg::pixel_type  in_pixel,
   output logic                 out_valid,
   input  logic                 out_ready,
   output srpd_pkg::pixel_type  out_pixel
);
   import srpd_pkg::*;

   logic      valid_ff, valid_in;
   pixel_type pixel_ff, pixel_in;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      pixel_in = pixel_ff;
      if (in_ready) begin
         valid_in = in_valid;
         pixel_in = in_pixel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pixel_ff <= pixel_in;
   end

   assign out_valid = valid_ff;
   assign out_pixel = pixel_ff;

endmodule

[design/sprite_row_planar_decode.sv]
// ----------------------------------------------------------------------------
// sprite_row_planar_decode
// planar to chunky decode of one 16-pixel, 4 bits per pixel sprite row
// ----------------------------------------------------------------------------
// channel  dir  tdata                              tuser                  tlast
// req      in   plane_zero..plane_three (64 bits)  palette,mirror,front   -
// rsp      out  pixel_offset, color_index          opaque, front_mark     last_pixel
//
// each row transfer yields sixteen pixel transfers, one per cycle when rsp is
// ready; the pixel counter sets that the next row is taken in the cycle its
// predecessor's last pixel moves on
// reset is synchronous, active high, and clears the row and result valid flags
// a stall on rsp freezes the pixel counter; nothing is dropped or repeated
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sprite_row_planar_decode (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // plane_zero[15:0], plane_one[31:16], plane_two[47:32], plane_three[63:48]
   input  logic [srpd_pkg::REQ_DATA_W-1:0]   req_tdata,
   // palette_number[3:0], mirror[4], in_front[5]
   input  logic [srpd_pkg::REQ_USER_W-1:0]   req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // pixel_offset[3:0], color_index[11:4], zero fill[15:12]
   output logic [srpd_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // opaque[0], front_mark[1]
   output logic [srpd_pkg::RSP_USER_W-1:0]   rsp_tuser,
   output logic                              rsp_tlast
);
   import srpd_pkg::*;

   // row buffer and pixel counter
   logic                row_valid_ff, row_valid_in;
   row_type             row_ff, row_in;
   logic [OFFSET_W-1:0] count_ff, count_in;

   logic      pix_ready;
   logic      advance;
   logic      row_done;
   logic      req_xfer;
   logic      rsp_at_last;
   pixel_type pixel;
   pixel_type rsp_pixel;

   // a pixel moves into the result register
   assign advance  = row_valid_ff && pix_ready;
   assign row_done = advance && (count_ff == LAST_OFFSET);

   // take a new row when empty or while the last pixel leaves
   assign req_tready = !row_valid_ff || row_done;
   assign req_xfer   = req_tvalid && req_tready;

   always_comb begin
      row_valid_in = row_valid_ff;
      row_in       = row_ff;
      count_in     = count_ff;
      if (advance) begin
         count_in = count_ff + 1'b1;
      end
      if (row_done) begin
         row_valid_in = 1'b0;
      end
      if (req_xfer) begin
         row_valid_in        = 1'b1;
         count_in            = '0;
         row_in.plane[0]     = req_tdata[PLANE_W-1:0];
         row_in.plane[1]     = req_tdata[2*PLANE_W-1:PLANE_W];
         row_in.plane[2]     = req_tdata[3*PLANE_W-1:2*PLANE_W];
         row_in.plane[3]     = req_tdata[4*PLANE_W-1:3*PLANE_W];
         row_in.palette_number = req_tuser[PAL_W-1:0];
         row_in.mirror       = req_tuser[PAL_W];
         row_in.in_front     = req_tuser[PAL_W+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         row_valid_ff <= row_valid_in;
         count_ff     <= count_in;
      end
   end

   // row payload needs no reset
   always_ff @(posedge clock) begin
      row_ff <= row_in;
   end

   srpd_pixel_sel u_pixel_sel (
      .row    (row_ff),
      .offset (count_ff),
      .pixel  (pixel)
   );

   srpd_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (row_valid_ff),
      .in_ready  (pix_ready),
      .in_pixel  (pixel),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_pixel (rsp_pixel)
   );

   // pack the result transfer
   assign rsp_tdata = {{(RSP_DATA_W-OFFSET_W-COLOR_W){1'b0}},
                       rsp_pixel.color_index, rsp_pixel.pixel_offset};
   assign rsp_tuser = {rsp_pixel.front_mark, rsp_pixel.opaque};
   assign rsp_tlast = rsp_pixel.last_pixel;

   assign rsp_at_last = (rsp_pixel.pixel_offset == LAST_OFFSET);

   // a new row always starts at the leftmost pixel
   `ASSERT_NEXT(a_row_starts_at_zero, clock, reset, req_xfer, row_valid_ff && count_ff == '0)

   // no new row while one is partly sent, until its last pixel leaves
   `ASSERT_IMPLIES(a_no_take_mid_row, clock, reset, row_valid_ff && !row_done, !req_tready)

   // tlast marks exactly the final offset
   `ASSERT_IMPLIES(a_last_matches_offset, clock, reset, rsp_tvalid, rsp_tlast == rsp_at_last)

endmodule
